>>> hw/rtl/kps_pkg.sv
// Shared types and constants for the keyframe pair search core.
`default_nettype none

package kps_pkg;

  localparam int TIME_W = 16;
  localparam int IDX_W  = 9;
  localparam int FRAC_W = 16;
  localparam int OUT_W  = 8;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  typedef logic [TIME_W-1:0] key_time_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [FRAC_W-1:0] frac_t;

  // Operation codes of an input transaction.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Register index, taken from paddr[2].
  localparam logic REG_KEY_COUNT = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_LAST,
    S_CLASSIFY,
    S_CHECK,
    S_FWD,
    S_BWD,
    S_DIV_START,
    S_DIV_WAIT,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/keyframe_pair_search_core.sv
// Keyframe pair search: key table, walk sequencer and fraction divider.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------------------
//   in      | input     | in_valid/in_ready  | op, key_index, key_time, anim_time, cached_key
//   out     | output    | out_valid/out_ready| new_cached_key, from_index, to_index, fraction
//   apb     | input     | psel/penable/pready| paddr, pwrite, pwdata, prdata (key_count)
//
// A write transaction is taken in idle. A query reads the last key and classifies:
// at or beyond the end keys it finishes there, on an exact hit on the cached key
// after the first check, else it walks with one table read per step after the first
// check, then waits on the divider. Without a division (fraction zero or saturated) it skips that wait.
// Reset clears control state only; key table contents stay undefined until written.
// A finished result sits in the output register; the next transaction is taken
// while it waits, and a later query holds in its last state until the slot frees.
`default_nettype none

module keyframe_pair_search_core #(
  parameter int MAX_KEYS = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  // input transactions
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          op,
  input  logic [7:0]                    key_index,
  input  logic [15:0]                   key_time,
  input  logic [15:0]                   anim_time,
  input  logic [7:0]                    cached_key,
  // results
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    new_cached_key,
  output logic [7:0]                    from_index,
  output logic [7:0]                    to_index,
  output logic [15:0]                   fraction,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kps_pkg::APB_AW-1:0]    paddr,
  input  logic [kps_pkg::APB_DW-1:0]    pwdata,
  output logic [kps_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import kps_pkg::*;

  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

  state_t    state, state_next;

  idx_t      key_count;
  idx_t      kc_eff;
  idx_t      last_calc;

  key_time_t t;
  idx_t      last;
  idx_t      cur;
  idx_t      ptr;
  idx_t      from_idx;
  idx_t      to_idx;
  key_time_t k0;
  key_time_t klast;
  key_time_t kcur;
  key_time_t kf;
  key_time_t kt;
  frac_t     frac;

  idx_t      cur_sat;
  idx_t      cur_inc;
  idx_t      cur_dec;
  idx_t      ptr_inc;
  idx_t      ptr_dec;
  idx_t      rd_idx;

  logic          mem_we;
  key_time_t     rdata;
  key_time_t     num;
  key_time_t     den;
  logic          frac_ok;
  logic          frac_sat;
  logic          div_start;
  logic          div_done;
  frac_t         div_quo;
  logic          out_free;
  logic          cfg_write;

  // ---------------- configuration ----------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= IDX_W'(1);
    end else if (cfg_write && paddr[2] == REG_KEY_COUNT) begin
      key_count <= pwdata[IDX_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_KEY_COUNT) ? APB_DW'(key_count) : '0;

  // Effective last key index, key_count clamped to 1..MAX_KEYS.
  assign kc_eff    = (key_count == '0) ? IDX_W'(1) : key_count;
  assign last_calc = (32'(kc_eff) > MAX_KEYS) ? IDX_W'(MAX_KEYS - 1)
                                                : kc_eff - IDX_W'(1);

  // ---------------- key table ----------------
  assign mem_we = in_valid && in_ready && (op == OP_WRITE) &&
                  (32'(key_index) < MAX_KEYS);

  kps_key_mem #(
    .DEPTH (MAX_KEYS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(key_index)),
    .wdata (key_time),
    .raddr (AW'(rd_idx)),
    .rdata (rdata)
  );

  // ---------------- fraction divider ----------------
  assign frac_ok  = (kt > kf) && (t >= kf);
  assign num      = t - kf;
  assign den      = kt - kf;
  assign frac_sat = num >= den;

  kps_frac_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // ---------------- sequencer ----------------
  assign cur_sat  = (cur > last) ? last : cur;
  assign cur_inc  = cur + IDX_W'(1);
  assign cur_dec  = cur - IDX_W'(1);
  assign ptr_inc  = ptr + IDX_W'(1);
  assign ptr_dec  = ptr - IDX_W'(1);
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && op == OP_QUERY) state_next = S_RD_LAST;
      end
      S_RD_LAST: state_next = S_CLASSIFY;
      S_CLASSIFY: begin
        if (t <= k0 || rdata <= t) state_next = S_DONE;
        else                       state_next = S_CHECK;
      end
      S_CHECK: begin
        if (rdata < t) begin
          state_next = (cur_inc < last) ? S_FWD : S_DIV_START;
        end else if (rdata == t) begin
          state_next = S_DONE;
        end else begin
          state_next = (cur > IDX_W'(1)) ? S_BWD : S_DIV_START;
        end
      end
      S_FWD: begin
        if (!(rdata <= t && ptr_inc < last)) state_next = S_DIV_START;
      end
      S_BWD: begin
        if (!(t <= rdata && ptr > IDX_W'(1))) state_next = S_DIV_START;
      end
      S_DIV_START: begin
        state_next = (frac_ok && !frac_sat) ? S_DIV_WAIT : S_DONE;
      end
      S_DIV_WAIT: begin
        if (div_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Read address for the next cycle's data, divider kick and input ready.
  always_comb begin
    in_ready  = (state == S_IDLE);
    div_start = (state == S_DIV_START) && frac_ok && !frac_sat;
    rd_idx    = '0;
    unique case (state)
      S_RD_LAST:  rd_idx = last;
      S_CLASSIFY: rd_idx = cur_sat;
      S_CHECK:    rd_idx = (rdata < t) ? cur_inc : cur_dec;
      S_FWD:      rd_idx = ptr_inc;
      S_BWD:      rd_idx = ptr_dec;
      default:    rd_idx = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid && op == OP_QUERY) begin
          t    <= anim_time;
          cur  <= IDX_W'(cached_key);
          last <= last_calc;
        end
      end
      S_RD_LAST: k0 <= rdata;
      S_CLASSIFY: begin
        frac <= '0;
        if (t <= k0) begin
          cur      <= '0;
          from_idx <= '0;
          to_idx   <= '0;
        end else if (rdata <= t) begin
          cur      <= last;
          from_idx <= last;
          to_idx   <= last;
        end else begin
          cur   <= cur_sat;
          klast <= rdata;
        end
      end
      S_CHECK: begin
        kcur <= rdata;
        if (rdata < t) begin
          ptr <= cur_inc;
          if (!(cur_inc < last)) begin
            from_idx <= cur;
            kf       <= rdata;
            to_idx   <= cur_inc;
            kt       <= klast;
          end
        end else if (rdata == t) begin
          from_idx <= cur;
          to_idx   <= cur;
        end else begin
          ptr <= cur_dec;
          if (!(cur > IDX_W'(1))) begin
            from_idx <= '0;
            kf       <= k0;
            to_idx   <= cur;
            kt       <= rdata;
          end
        end
      end
      S_FWD: begin
        if (rdata <= t) begin
          cur  <= ptr;
          kcur <= rdata;
          if (ptr_inc < last) begin
            ptr <= ptr_inc;
          end else begin
            from_idx <= ptr;
            kf       <= rdata;
            to_idx   <= ptr_inc;
            kt       <= klast;
          end
        end else begin
          from_idx <= cur;
          kf       <= kcur;
          to_idx   <= ptr;
          kt       <= rdata;
        end
      end
      S_BWD: begin
        if (t <= rdata) begin
          cur  <= ptr;
          kcur <= rdata;
          if (ptr > IDX_W'(1)) begin
            ptr <= ptr_dec;
          end else begin
            from_idx <= '0;
            kf       <= k0;
            to_idx   <= ptr;
            kt       <= rdata;
          end
        end else begin
          from_idx <= ptr;
          kf       <= rdata;
          to_idx   <= cur;
          kt       <= kcur;
        end
      end
      S_DIV_START: begin
        // time equal to the to-key saturates to just below one
        if (!frac_ok)     frac <= '0;
        else if (frac_sat) frac <= '1;
      end
      S_DIV_WAIT: begin
        if (div_done) frac <= div_quo;
      end
      S_DONE: begin
        if (out_free) begin
          new_cached_key <= cur[OUT_W-1:0];
          from_index     <= from_idx[OUT_W-1:0];
          to_index       <= to_idx[OUT_W-1:0];
          fraction       <= frac;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/kps_key_mem.sv
// Key time table: one write port, one read port with registered read data.
`default_nettype none

module kps_key_mem #(
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  kps_pkg::key_time_t     wdata,
  input  logic [AW-1:0]          raddr,
  output kps_pkg::key_time_t     rdata
);
  import kps_pkg::*;

  key_time_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/kps_frac_div.sv
// Shift-subtract divider for the Q0.16 fraction, one quotient bit per cycle.
`default_nettype none

module kps_frac_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  kps_pkg::key_time_t num,   // num < den
  input  kps_pkg::key_time_t den,
  output logic               done,
  output kps_pkg::frac_t     quo
);
  import kps_pkg::*;

  localparam int CNT_W = $clog2(FRAC_W + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  key_time_t         rem;
  key_time_t         dsr;
  logic [TIME_W:0]   shifted;
  logic              take;

  assign shifted = {rem, 1'b0};
  assign take    = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(FRAC_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsr <= den;
      quo <= '0;
    end else if (busy) begin
      rem <= take ? TIME_W'(shifted - {1'b0, dsr}) : TIME_W'(shifted);
      quo <= {quo[FRAC_W-2:0], take};
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/kps_checker.sv
// Port-level checks for the keyframe pair search core, bound to the top level.
`default_nettype none

module kps_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          op,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [7:0]                    new_cached_key,
  input logic [7:0]                    from_index,
  input logic [7:0]                    to_index,
  input logic [15:0]                   fraction,
  input logic                          pready
);
  import kps_pkg::*;

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(new_cached_key) &&
      $stable(from_index) && $stable(to_index) && $stable(fraction))
    else $error("result changed while stalled");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

  // A query keeps the input side busy on the following cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && op == OP_QUERY |=> !in_ready)
    else $error("input taken during a query");

  // New results come out of the final query state, never out of idle.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a query in flight");

  a_frac_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && from_index == to_index |-> fraction == '0)
    else $error("nonzero fraction for a single key");

endmodule

bind keyframe_pair_search_core kps_checker u_kps_checker (.*);

`default_nettype wire

>>> tb/sv/keyframe_pair_search_core_test.sv
// Self-checking testbench for the keyframe pair search core: key table loads and pair queries.
`timescale 1ns / 100ps

module keyframe_pair_search_core_test;
  import kps_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int SETTLE_CYCLES = 64;
  localparam int LIMIT_CYCLES  = 4_000_000;
  localparam int NUM_PHASES    = 10;
  localparam int RANDOM_ITEMS  = 35;
  localparam int MAX_REPORTS   = 60;
  localparam logic [APB_AW-1:0] KEY_COUNT_ADDR = {REG_KEY_COUNT, 2'b00};

  typedef struct packed {
    logic [7:0] new_cached;
    logic [7:0] from_idx;
    logic [7:0] to_idx;
    frac_t      frac;
  } pair_result_t;

  class pair_search_board;
    key_time_t    key_tab [256];
    logic [8:0]   key_count;
    logic [7:0]   last_cached;
    pair_result_t pair_q [$];
    int           errors;

    function new();
      foreach (key_tab[i]) key_tab[i] = '0;
      key_count   = 9'd1;
      last_cached = 8'd0;
      errors      = 0;
    endfunction

    // index of the last key in use; a count of 0 acts as 1, above 256 as 256
    function int active_last();
      int n;
      n = int'(key_count);
      if (n == 0) n = 1;
      if (n > 256) n = 256;
      return n - 1;
    endfunction

    function pair_result_t search_pair(input int t, input int ck);
      int last, cur, from_i, to_i, nxt, prv, tf, tt;
      longint num, den, fr;
      pair_result_t r;
      last = active_last();
      cur  = ck;
      fr   = 0;
      if (t <= int'(key_tab[0])) begin
        cur = 0; from_i = 0; to_i = 0;
      end else if (int'(key_tab[last]) <= t) begin
        cur = last; from_i = last; to_i = last;
      end else begin
        if (cur > last) cur = last;
        if (int'(key_tab[cur]) < t) begin
          nxt = cur + 1;
          while (nxt < last && int'(key_tab[nxt]) <= t) begin
            cur = nxt;
            nxt++;
          end
          from_i = cur;
          to_i   = nxt;
        end else if (int'(key_tab[cur]) == t) begin
          from_i = cur;
          to_i   = cur;
        end else begin
          // cur >= 1 here: key 0 lies below t
          prv = cur - 1;
          while (prv > 0 && t <= int'(key_tab[prv])) begin
            cur = prv;
            prv--;
          end
          from_i = prv;
          to_i   = cur;
        end
        if (from_i != to_i) begin
          tf = int'(key_tab[from_i]);
          tt = int'(key_tab[to_i]);
          if (tt > tf && t >= tf) begin
            num = longint'(t - tf);
            den = longint'(tt - tf);
            fr  = (num << 16) / den;
            if (fr > 65535) fr = 65535;  // t on the to-key saturates
          end
        end
      end
      r.new_cached = 8'(cur);
      r.from_idx   = 8'(from_i);
      r.to_idx     = 8'(to_i);
      r.frac       = 16'(fr);
      return r;
    endfunction

    function void note_input(input logic o, input logic [7:0] ki, input key_time_t kt,
                             input key_time_t at, input logic [7:0] ck);
      pair_result_t r;
      if (o == OP_WRITE) begin
        key_tab[ki] = kt;
      end else begin
        r = search_pair(int'(at), int'(ck));
        last_cached = r.new_cached;
        pair_q.push_back(r);
      end
    endfunction

    function void compare_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
        if (errors < MAX_REPORTS)
          $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(input logic [7:0] nc, input logic [7:0] fi,
                               input logic [7:0] ti, input frac_t fr);
      pair_result_t e;
      if (pair_q.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("%0t: unexpected result: expected none, actual %0d/%0d/%0d/%0d",
                   $time, nc, fi, ti, fr);
        errors++;
        return;
      end
      e = pair_q.pop_front();
      compare_field("new_cached_key", int'(e.new_cached), int'(nc));
      compare_field("from_index", int'(e.from_idx), int'(fi));
      compare_field("to_index", int'(e.to_idx), int'(ti));
      compare_field("fraction", int'(e.frac), int'(fr));
    endfunction

    function int pending();
      return pair_q.size();
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic                op;
  logic [7:0]          key_index;
  logic [15:0]         key_time;
  logic [15:0]         anim_time;
  logic [7:0]          cached_key;
  logic                out_valid;
  logic                out_ready;
  logic [7:0]          new_cached_key;
  logic [7:0]          from_index;
  logic [7:0]          to_index;
  logic [15:0]         fraction;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  pair_search_board sb;
  int               send_gap_pct;
  int               stall_pct;
  int               track_time;
  int               cycles;

  keyframe_pair_search_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .key_index      (key_index),
    .key_time       (key_time),
    .anim_time      (anim_time),
    .cached_key     (cached_key),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .new_cached_key (new_cached_key),
    .from_index     (from_index),
    .to_index       (to_index),
    .fraction       (fraction),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    op           = OP_WRITE;
    key_index    = '0;
    key_time     = '0;
    anim_time    = '0;
    cached_key   = '0;
    out_ready    = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    send_gap_pct = 0;
    stall_pct    = 0;
    track_time   = 0;
    cycles       = 0;
    sb           = new();
  end

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= (int'($urandom_range(0, 99)) >= stall_pct);
  end

  // transaction monitors
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.note_input(op, key_index, key_time, anim_time, cached_key);
      if (out_valid && out_ready)
        sb.check_result(new_cached_key, from_index, to_index, fraction);
    end
  end

  // entered and left at a falling edge; valid stays high for a back-to-back transaction
  task automatic send_item(input logic o, input logic [7:0] ki, input logic [15:0] kt,
                           input logic [15:0] at, input logic [7:0] ck);
    while (int'($urandom_range(0, 99)) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    op         <= o;
    key_index  <= ki;
    key_time   <= kt;
    anim_time  <= at;
    cached_key <= ck;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic stop_input();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_key_count(input int value);
    stop_input();
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= KEY_COUNT_ADDR;
    pwdata  <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.key_count = 9'(value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // fresh increasing track over the active keys
  task automatic refresh_table();
    int nn, g, kt, i, d;
    nn = sb.active_last() + 1;
    kt = int'($urandom_range(0, 3000));
    g  = (62000 - kt) * 2 / nn;
    if (g < 1) g = 1;
    for (i = 0; i < nn; i++) begin
      if (kt > 65535) kt = 65535;
      send_item(OP_WRITE, 8'(i), 16'(kt), 16'($urandom), 8'($urandom));
      d  = int'($urandom_range(1, g));
      kt = kt + d;
    end
  endtask

  task automatic gen_and_send();
    int sel, last, i, lo, hi, span, g, d, t, ck;
    logic       o;
    logic [7:0] ki;
    logic [15:0] kt;
    last = sb.active_last();
    sel  = int'($urandom_range(0, 99));
    o    = OP_QUERY;
    ki   = 8'($urandom_range(0, 255));
    kt   = 16'($urandom_range(0, 65535));
    t    = int'($urandom_range(0, 65535));
    ck   = int'($urandom_range(0, 255));
    if (sel < 12) begin
      o = OP_WRITE;
      if ($urandom_range(0, 9) < 7) ki = 8'($urandom_range(0, last));
      i  = int'(ki);
      lo = (i == 0) ? 0 : int'(sb.key_tab[i - 1]) + 1;
      hi = (i == 255) ? 65535 : int'(sb.key_tab[i + 1]) - 1;
      // mostly keep the track ordered; the rest scrambles it
      if ($urandom_range(0, 9) < 6 && lo <= hi) kt = 16'($urandom_range(hi, lo));
    end else if (sel < 55) begin
      // playback: time creeps along, cached key fed back from the last query
      span = int'(sb.key_tab[last]) - int'(sb.key_tab[0]);
      g    = span / (last + 1) + 1;
      if (g < 1) g = 64;
      d = int'($urandom_range(0, g));
      if ($urandom_range(0, 4) == 0) track_time = track_time - d;
      else track_time = track_time + d;
      if (track_time > int'(sb.key_tab[last]) + g || track_time < 0 ||
          $urandom_range(0, 99) == 0) begin
        track_time = int'(sb.key_tab[0]) - int'($urandom_range(0, g));
        if (track_time < 0) track_time = 0;
      end
      if (track_time > 65535) track_time = 65535;
      t  = track_time;
      ck = int'(sb.last_cached);
    end else if (sel < 75) begin
      i = int'($urandom_range(0, last));
      t = int'(sb.key_tab[i]) + int'($urandom_range(0, 2)) - 1;
      if (t < 0) t = 0;
      if (t > 65535) t = 65535;
      if ($urandom_range(0, 1) == 0) ck = int'($urandom_range(0, last));
      else ck = int'(sb.last_cached);
    end else if (sel >= 90) begin
      case ($urandom_range(0, 3))
        0: t = 0;
        1: t = 65535;
        2: t = int'(sb.key_tab[0]);
        default: t = int'(sb.key_tab[last]);
      endcase
      case ($urandom_range(0, 3))
        0: ck = 0;
        1: ck = 255;
        2: ck = last;
        default: ck = (last < 255) ? last + 1 : 255;
      endcase
    end
    send_item(o, ki, kt, 16'(t), 8'(ck));
  endtask

  initial begin : stimulus
    int i, ph;
    int phase_counts [NUM_PHASES];
    int dir_t  [12];
    int dir_ck [12];
    phase_counts = '{0, 2, 256, 511, 1, 300, 37, 0, 128, 257};
    phase_counts[7] = int'($urandom_range(3, 255));
    // key times 100 + 250*i; with 8 keys the last one sits at 1850
    dir_t  = '{0, 100, 65535, 1850, 1000, 600, 1601, 101, 349, 850, 1849, 0};
    dir_ck = '{3, 3, 0, 2, 255, 2, 0, 0, 1, 6, 7, 255};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (i = 0; i < 256; i++)
      send_item(OP_WRITE, 8'(i), 16'(100 + 250 * i), 16'($urandom), 8'($urandom));
    write_key_count(8);

    // ends, exact hits, both walks, oversized cached key, fraction near one
    for (i = 0; i < 12; i++)
      send_item(OP_QUERY, 8'($urandom), 16'($urandom), 16'(dir_t[i]), 8'(dir_ck[i]));
    send_item(OP_WRITE, 8'd255, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_item(OP_WRITE, 8'd0, 16'h0000, 16'h0000, 8'h00);
    send_item(OP_QUERY, 8'h00, 16'h0000, 16'd0, 8'd5);
    send_item(OP_QUERY, 8'hFF, 16'hFFFF, 16'd1, 8'd0);
    send_item(OP_WRITE, 8'd7, 16'hFFFF, 16'h0000, 8'h00);
    send_item(OP_QUERY, 8'h00, 16'h0000, 16'd65534, 8'd0);
    send_item(OP_QUERY, 8'h00, 16'h0000, 16'd65535, 8'd255);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      write_key_count(phase_counts[ph]);
      case (ph % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 63; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 63; end
        default: begin send_gap_pct = 13; stall_pct = 13; end
      endcase
      refresh_table();
      repeat (RANDOM_ITEMS) gen_and_send();
    end

    stop_input();
    wait_drained();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
